// ===== design/cec_pkg.sv =====
//------------------------------------------------------------------------------
// cec_pkg
// Shared types, constants and helpers of the curve endpoint chainer.
//------------------------------------------------------------------------------
`default_nettype none

package cec_pkg;

  localparam int COORD_W   = 32;
  localparam int TOLCFG_W  = 16;
  localparam int PC_W      = 16;
  localparam int POS_W     = 6;
  localparam int LEN_W     = POS_W + 1;
  localparam int OUT_LIMIT = 64;
  localparam logic [TOLCFG_W-1:0] TOL_RESET = 16'd66;
  localparam logic [PC_W-1:0]     RELAX_PC  = 16'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT_RD,
    ST_INIT_SET,
    ST_SCAN_RD,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic latch_tol;
    logic set_first;
    logic calc_diff;
    logic calc_sq;
    logic take;
    logic next_cand;
    logic set_broke;
    logic emit_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic single_curve;
    logic used;
    logic near_start;
    logic near_end;
    logic scan_last;
    logic chain_done;
    logic out_fire;
    logic emit_last;
  } status_t;

  // |a - b| over 33 bits, exact for any pair of 32-bit signed values
  function automatic logic [COORD_W:0] absdiff(coord_t a, coord_t b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
  endfunction

endpackage

`default_nettype wire

// ===== design/cec_if.sv =====
//------------------------------------------------------------------------------
// cec_if
// Valid/ready channels: curve input and chain entry output.
//------------------------------------------------------------------------------
`default_nettype none

interface cec_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [15:0]        point_count;
  logic               last_curve;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 point_count, last_curve, input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               point_count, last_curve, output ready);
endinterface

interface cec_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] chain_position;
  logic [5:0] curve_index;
  logic       reversed;
  logic       incomplete;
  logic       last_entry;

  modport source(output valid, chain_position, curve_index, reversed, incomplete,
                 last_entry, input ready);
  modport sink(input valid, chain_position, curve_index, reversed, incomplete,
               last_entry, output ready);
endinterface

`default_nettype wire

// ===== design/cec_ctrl.sv =====
//------------------------------------------------------------------------------
// cec_ctrl
// Sequencer: load, chain scan one candidate at a time, entry emission.
//------------------------------------------------------------------------------
`default_nettype none

module cec_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cec_pkg::status_t sts,
  output cec_pkg::cmd_t        cmd
);
  import cec_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (sts.in_fire && sts.in_last) state_next = ST_INIT_RD;
      end
      ST_INIT_RD:  state_next = ST_INIT_SET;
      ST_INIT_SET: state_next = sts.single_curve ? ST_EMIT_RD : ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_DIFF;
      ST_DIFF: begin
        if (!sts.used)          state_next = ST_SQ;
        else if (sts.scan_last) state_next = ST_EMIT_RD;
        else                    state_next = ST_SCAN_RD;
      end
      ST_SQ: state_next = ST_CMP;
      ST_CMP: begin
        if (sts.near_start || sts.near_end)
          state_next = sts.chain_done ? ST_EMIT_RD : ST_SCAN_RD;
        else if (sts.scan_last)
          state_next = ST_EMIT_RD;
        else
          state_next = ST_SCAN_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (sts.out_fire) state_next = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD:     cmd.in_ready  = 1'b1;
      ST_INIT_RD:  cmd.latch_tol = 1'b1;
      ST_INIT_SET: cmd.set_first = 1'b1;
      ST_SCAN_RD:  ;
      ST_DIFF: begin
        if (!sts.used)          cmd.calc_diff = 1'b1;
        else if (sts.scan_last) cmd.set_broke = 1'b1;
        else                    cmd.next_cand = 1'b1;
      end
      ST_SQ: cmd.calc_sq = 1'b1;
      ST_CMP: begin
        if (sts.near_start || sts.near_end) cmd.take      = 1'b1;
        else if (sts.scan_last)             cmd.set_broke = 1'b1;
        else                                cmd.next_cand = 1'b1;
      end
      ST_EMIT_RD: ;
      ST_EMIT_LD: cmd.emit_load = 1'b1;
      ST_EMIT_WAIT: begin
        if (sts.out_fire && sts.emit_last) cmd.finish = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cec_dp.sv =====
//------------------------------------------------------------------------------
// cec_dp
// Datapath: curve memories, distance pipeline, chain result store, output reg.
//------------------------------------------------------------------------------
`default_nettype none

module cec_dp #(
  parameter int MAX_CURVES   = 64,
  parameter int RELAX_FACTOR = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata,
  input  wire cec_pkg::cmd_t    cmd,
  output cec_pkg::status_t      sts,
  cec_in_if.sink                curve_in,
  cec_out_if.source             chain_out
);
  import cec_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CURVES);
  localparam int CNT_W  = $clog2(MAX_CURVES + 1);
  localparam int TOL_W  = $clog2(65535 * RELAX_FACTOR + 1);
  localparam int SQ_W   = 2 * TOL_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RES_W  = POS_W + 1;

  // storage
  point_t           start_mem [MAX_CURVES];
  point_t           end_mem   [MAX_CURVES];
  logic             used_mem  [MAX_CURVES];
  logic [RES_W-1:0] res_mem   [OUT_LIMIT];

  point_t           rd_start, rd_end;
  logic             rd_used;
  logic [RES_W-1:0] res_q;

  logic [CNT_W-1:0]    count;
  logic                relaxed, overflow, broke;
  logic [TOLCFG_W-1:0] base_tol;
  logic [TOL_W-1:0]    tol;
  logic [SQ_W-1:0]     tol_sq;
  point_t              cur_end;
  logic [IDX_W-1:0]    scan_idx;
  logic [LEN_W-1:0]    len;
  logic [POS_W-1:0]    emit_idx;

  logic [TOL_W-1:0] ad_s [3];
  logic [TOL_W-1:0] ad_e [3];
  logic             lt_s, lt_e;
  logic [SQ_W-1:0]  sq_s [3];
  logic [SQ_W-1:0]  sq_e [3];
  logic [SUM_W-1:0] sum_s, sum_e;

  logic       in_fire, room, take_rev;
  logic [COORD_W:0] d_s [3];
  logic [COORD_W:0] d_e [3];
  logic       used_we, used_wd;
  logic [IDX_W-1:0] used_wa;

  assign curve_in.ready = cmd.in_ready;
  assign in_fire = curve_in.valid && curve_in.ready;
  assign room    = count < CNT_W'(MAX_CURVES);

  // used flag write port: cleared on load, set when a curve joins the chain
  always_comb begin
    used_we = 1'b0;
    used_wa = scan_idx;
    used_wd = 1'b1;
    if (in_fire && room) begin
      used_we = 1'b1;
      used_wa = count[IDX_W-1:0];
      used_wd = 1'b0;
    end else if (cmd.set_first) begin
      used_we = 1'b1;
      used_wa = '0;
    end else if (cmd.take) begin
      used_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && room) begin
      start_mem[count[IDX_W-1:0]] <= '{curve_in.start_x, curve_in.start_y,
                                       curve_in.start_z};
      end_mem[count[IDX_W-1:0]]   <= '{curve_in.end_x, curve_in.end_y,
                                       curve_in.end_z};
    end
    if (used_we) used_mem[used_wa] <= used_wd;
    rd_start <= start_mem[scan_idx];
    rd_end   <= end_mem[scan_idx];
    rd_used  <= used_mem[scan_idx];
  end

  assign take_rev = !sts.near_start;

  always_ff @(posedge clk) begin
    if (cmd.set_first) res_mem[0] <= '0;
    else if (cmd.take) res_mem[len[POS_W-1:0]] <= {POS_W'(scan_idx), take_rev};
    res_q <= res_mem[emit_idx];
  end

  // distance pipeline: abs diffs, then squares, then sum and compare
  always_comb begin
    d_s[0] = absdiff(cur_end.x, rd_start.x);
    d_s[1] = absdiff(cur_end.y, rd_start.y);
    d_s[2] = absdiff(cur_end.z, rd_start.z);
    d_e[0] = absdiff(cur_end.x, rd_end.x);
    d_e[1] = absdiff(cur_end.y, rd_end.y);
    d_e[2] = absdiff(cur_end.z, rd_end.z);
  end

  always_ff @(posedge clk) begin
    tol_sq <= SQ_W'(tol) * SQ_W'(tol);
    if (cmd.calc_diff) begin
      for (int k = 0; k < 3; k++) begin
        ad_s[k] <= d_s[k][TOL_W-1:0];
        ad_e[k] <= d_e[k][TOL_W-1:0];
      end
      lt_s <= (d_s[0] < (COORD_W+1)'(tol)) && (d_s[1] < (COORD_W+1)'(tol)) &&
              (d_s[2] < (COORD_W+1)'(tol));
      lt_e <= (d_e[0] < (COORD_W+1)'(tol)) && (d_e[1] < (COORD_W+1)'(tol)) &&
              (d_e[2] < (COORD_W+1)'(tol));
    end
    if (cmd.calc_sq) begin
      for (int k = 0; k < 3; k++) begin
        sq_s[k] <= SQ_W'(ad_s[k]) * SQ_W'(ad_s[k]);
        sq_e[k] <= SQ_W'(ad_e[k]) * SQ_W'(ad_e[k]);
      end
    end
  end

  assign sum_s = SUM_W'(sq_s[0]) + SUM_W'(sq_s[1]) + SUM_W'(sq_s[2]);
  assign sum_e = SUM_W'(sq_e[0]) + SUM_W'(sq_e[1]) + SUM_W'(sq_e[2]);

  // profile and chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      relaxed  <= 1'b0;
      overflow <= 1'b0;
      broke    <= 1'b0;
      base_tol <= TOL_RESET;
      cur_end  <= '0;
      scan_idx <= '0;
      len      <= '0;
      emit_idx <= '0;
      chain_out.valid <= 1'b0;
    end else begin
      if (cfg_we) base_tol <= cfg_wdata;
      if (in_fire) begin
        if (room) begin
          count <= count + CNT_W'(1);
          if (curve_in.point_count <= RELAX_PC) relaxed <= 1'b1;
        end else begin
          overflow <= 1'b1;
        end
        if (curve_in.last_curve) begin
          scan_idx <= '0;
          emit_idx <= '0;
        end
      end
      if (cmd.set_first) begin
        cur_end <= rd_end;
        len     <= LEN_W'(1);
      end
      if (cmd.next_cand) scan_idx <= scan_idx + IDX_W'(1);
      if (cmd.set_broke) broke <= 1'b1;
      if (cmd.take) begin
        cur_end  <= sts.near_start ? rd_end : rd_start;
        len      <= len + LEN_W'(1);
        scan_idx <= '0;
        if ((len + LEN_W'(1) == LEN_W'(OUT_LIMIT)) &&
            (CW'(count) > CW'(OUT_LIMIT)))
          broke <= 1'b1;
      end
      if (cmd.emit_load) begin
        chain_out.valid <= 1'b1;
        emit_idx        <= emit_idx + POS_W'(1);
      end else if (chain_out.valid && chain_out.ready) begin
        chain_out.valid <= 1'b0;
      end
      if (cmd.finish) begin
        count    <= '0;
        relaxed  <= 1'b0;
        overflow <= 1'b0;
        broke    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_tol) begin
      tol <= relaxed ? TOL_W'(base_tol) * TOL_W'(RELAX_FACTOR) : TOL_W'(base_tol);
    end
    if (cmd.emit_load) begin
      chain_out.chain_position <= emit_idx;
      chain_out.curve_index    <= res_q[RES_W-1:1];
      chain_out.reversed       <= res_q[0];
      chain_out.incomplete     <= broke || overflow;
      chain_out.last_entry     <= (LEN_W'(emit_idx) + LEN_W'(1)) == len;
    end
  end

  always_comb begin
    sts.in_fire      = in_fire;
    sts.in_last      = curve_in.last_curve;
    sts.single_curve = count == CNT_W'(1);
    sts.used         = rd_used;
    sts.near_start   = lt_s && (sum_s < SUM_W'(tol_sq));
    sts.near_end     = lt_e && (sum_e < SUM_W'(tol_sq));
    sts.scan_last    = (CNT_W'(scan_idx) + CNT_W'(1)) == count;
    sts.chain_done   = ((CW'(len) + CW'(1)) == CW'(count)) ||
                       ((len + LEN_W'(1)) == LEN_W'(OUT_LIMIT));
    sts.out_fire     = chain_out.valid && chain_out.ready;
    sts.emit_last    = chain_out.last_entry;
  end

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> !curve_in.ready)
    else $error("input accepted while an entry is pending");
  a_take_unused: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !rd_used)
    else $error("used curve taken into chain");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (len < LEN_W'(OUT_LIMIT)) && (CW'(len) < CW'(count)))
    else $error("chain length exceeds bound");
`endif

endmodule

`default_nettype wire

// ===== design/curve_endpoint_chainer.sv =====
//------------------------------------------------------------------------------
// curve_endpoint_chainer
// Greedy chaining of curve segments by endpoint proximity.
//------------------------------------------------------------------------------
// Load: one curve per cycle into the point memories, ready held high.
// Chaining: curve 0 starts the chain, then for each position the candidates are
//   scanned one at a time by the single shared distance unit (used ones skipped).
// Emission: one chain entry at a time, each held until taken; no input meanwhile.
// Reset (rst, synchronous): empty profile, tolerance 66, output idle.
`default_nettype none

module curve_endpoint_chainer #(
  parameter int MAX_CURVES   = 64,
  parameter int RELAX_FACTOR = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  cec_in_if.sink           curve_in,
  cec_out_if.source        chain_out
);
  import cec_pkg::*;

  cmd_t    cmd;
  status_t sts;

  cec_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  cec_dp #(
    .MAX_CURVES   (MAX_CURVES),
    .RELAX_FACTOR (RELAX_FACTOR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .curve_in  (curve_in),
    .chain_out (chain_out)
  );

endmodule

`default_nettype wire
